// ===== design/rca_pkg.sv =====
// ----------------------------------------------------------------------------
// rca_pkg
// types and constants shared by the collider pool and its process engine
// ----------------------------------------------------------------------------
package rca_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PUSH    = 2'd1,
        OP_PROCESS = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_CLEARED = 3'd0,
        KIND_PUSHED  = 3'd1,
        KIND_FULL    = 3'd2,
        KIND_PAIR    = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

    localparam logic [31:0] COLOR_FLIP = 32'hffff_ffff;
    localparam int unsigned MAX_RESULTS = 33;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [14:0]        rect_w;
        logic [14:0]        rect_h;
        logic [31:0]        color_in;
        logic [15:0]        instance_id;
        logic               notify_enable;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  first_slot;
        logic [4:0]  second_slot;
        logic [15:0] first_instance;
        logic [15:0] second_instance;
        logic [31:0] first_color;
        logic [31:0] second_color;
        logic        first_notify;
        logic        second_notify;
        logic        last;
    } out_word_t;

    // static part of a collider: rectangle, group, owner
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [31:0]        group;
        logic [15:0]        inst;
        logic               notify;
    } coll_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PUSH,
        ST_A_RD,
        ST_A_WAIT,
        ST_B_RD,
        ST_B_CMP,
        ST_FLIP_A,
        ST_FLIP_B,
        ST_EMIT,
        ST_DONE
    } state_t;

    function automatic logic overlap(input coll_t a, input coll_t b);
        logic signed [16:0] ax, ay, bx, by, axw, ayh, bxw, byh;
        begin
            ax  = 17'(a.x);
            ay  = 17'(a.y);
            bx  = 17'(b.x);
            by  = 17'(b.y);
            axw = ax + $signed({2'b00, a.w});
            ayh = ay + $signed({2'b00, a.h});
            bxw = bx + $signed({2'b00, b.w});
            byh = by + $signed({2'b00, b.h});
            overlap = (ax < bxw) && (bx < axw) && (ay < byh) && (by < ayh);
        end
    endfunction

endpackage

// ===== design/rca_engine.sv =====
// ----------------------------------------------------------------------------
// rca_engine
// collider memories, slot flags and the clear / push / process sequencer
// ----------------------------------------------------------------------------
module rca_engine #(
    parameter int SLOTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rca_pkg::in_word_t cmd,
    output logic              busy,
    output logic              res_valid,
    output rca_pkg::out_word_t res,
    input  logic              res_take
);
    import rca_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // static collider data, one read port, registered read
    coll_t       coll_mem [SLOTS];
    logic [31:0] color_mem [SLOTS];

    logic [SLOTS-1:0] expired_reg, expired_next;
    logic [SLOTS-1:0] touched_reg, touched_next;
    logic [CW-1:0]    used_reg, used_next;

    state_t state_reg, state_next;
    in_word_t cmd_reg;
    logic [IW-1:0] a_reg, a_next, b_reg, b_next;
    logic [CW-1:0] bcnt_reg, bcnt_next;
    logic [CW-1:0] acnt_reg, acnt_next;
    logic [5:0]    nres_reg, nres_next;
    coll_t a_data_reg;
    logic [31:0] a_color_reg;
    logic [IW-1:0] push_slot_reg, push_slot_next;
    logic          full_reg, full_next;

    logic [IW-1:0] rd_addr;
    coll_t         rd_coll;
    logic [31:0]   rd_color;
    logic          wr_coll, wr_color;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_color_data;

    logic          res_valid_reg, res_valid_next;
    out_word_t     res_reg, res_next;
    // pair word held here until the output register is free
    out_word_t     pair_reg, pair_next;

    always_ff @(posedge clk)
    begin
        if (wr_coll)
        begin
            coll_mem[wr_addr] <= '{x: cmd_reg.rect_x, y: cmd_reg.rect_y,
                                   w: cmd_reg.rect_w, h: cmd_reg.rect_h,
                                   group: cmd_reg.color_in,
                                   inst: cmd_reg.instance_id,
                                   notify: cmd_reg.notify_enable};
        end
        if (wr_color)
        begin
            color_mem[wr_addr] <= wr_color_data;
        end
        rd_coll  <= coll_mem[rd_addr];
        rd_color <= color_mem[rd_addr];
    end

    // highest-numbered expired slot below the used count
    logic          exp_found;
    logic [IW-1:0] exp_slot;
    always_comb
    begin
        exp_found = 1'b0;
        exp_slot  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (expired_reg[i] && (CW'(i) < used_reg))
            begin
                exp_found = 1'b1;
                exp_slot  = IW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            expired_reg   <= '0;
            touched_reg   <= '0;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            expired_reg   <= expired_next;
            touched_reg   <= touched_next;
            used_reg      <= used_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == ST_IDLE)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == ST_A_WAIT)
        begin
            a_data_reg  <= rd_coll;
            a_color_reg <= rd_color;
        end
        a_reg         <= a_next;
        b_reg         <= b_next;
        acnt_reg      <= acnt_next;
        bcnt_reg      <= bcnt_next;
        nres_reg      <= nres_next;
        push_slot_reg <= push_slot_next;
        full_reg      <= full_next;
        res_reg       <= res_next;
        pair_reg      <= pair_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign busy      = (state_reg != ST_IDLE) || res_valid_reg;

    logic out_free;
    assign out_free = !res_valid_reg || res_take;

    // slot looked at in ST_A_RD
    logic [IW-1:0] a_cand;
    assign a_cand = IW'(acnt_reg - CW'(1));

    logic a_live, b_ok;
    assign a_live = !expired_reg[a_cand] && !touched_reg[a_cand];
    assign b_ok   = !expired_reg[b_reg] && (b_reg != a_reg)
                    && (rd_coll.group != a_data_reg.group)
                    && overlap(a_data_reg, rd_coll);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.opcode)
                        OP_CLEAR:   state_next = ST_CLEAR;
                        OP_PUSH:    state_next = ST_PUSH;
                        OP_PROCESS: state_next = ST_A_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:  if (out_free) state_next = ST_IDLE;
            ST_PUSH:   if (out_free) state_next = ST_IDLE;
            ST_A_RD:
            begin
                if (acnt_reg == '0)
                    state_next = ST_DONE;
                else if (a_live)
                    state_next = ST_A_WAIT;
            end
            ST_A_WAIT: state_next = (used_reg == '0) ? ST_A_RD : ST_B_RD;
            ST_B_RD:   state_next = ST_B_CMP;
            ST_B_CMP:
            begin
                if (b_ok)
                    state_next = ST_FLIP_A;
                else if (bcnt_reg == CW'(1))
                    state_next = ST_A_RD;
                else
                    state_next = ST_B_RD;
            end
            ST_FLIP_A: state_next = ST_FLIP_B;
            ST_FLIP_B: state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_A_RD;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        expired_next   = expired_reg;
        touched_next   = touched_reg;
        used_next      = used_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acnt_next      = acnt_reg;
        bcnt_next      = bcnt_reg;
        nres_next      = nres_reg;
        push_slot_next = push_slot_reg;
        full_next      = full_reg;
        rd_addr        = a_reg;
        wr_coll        = 1'b0;
        wr_color       = 1'b0;
        wr_addr        = push_slot_reg;
        wr_color_data  = cmd_reg.color_in;
        res_next       = res_reg;
        pair_next      = pair_reg;
        res_valid_next = res_valid_reg && !res_take;
        unique case (state_reg)
            ST_IDLE:
            begin
                acnt_next = used_reg;
                nres_next = '0;
                full_next = !exp_found && (used_reg >= CW'(SLOTS));
                push_slot_next = exp_found ? exp_slot : used_reg[IW-1:0];
                if (start && cmd.opcode == OP_CLEAR)
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (CW'(i) < used_reg) expired_next[i] = 1'b1;
                end
            end
            ST_CLEAR, ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '0;
                    res_next.kind = (state_reg == ST_CLEAR) ? KIND_CLEARED : KIND_DONE;
                    res_next.last = 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '0;
                    res_next.last = 1'b1;
                    if (full_reg)
                        res_next.kind = KIND_FULL;
                    else
                    begin
                        res_next.kind = KIND_PUSHED;
                        res_next.second_slot = 5'(push_slot_reg);
                        wr_coll  = 1'b1;
                        wr_color = 1'b1;
                        expired_next[push_slot_reg] = 1'b0;
                        touched_next[push_slot_reg] = 1'b0;
                        if (CW'(push_slot_reg) == used_reg)
                            used_next = used_reg + CW'(1);
                    end
                end
            end
            ST_A_RD:
            begin
                rd_addr = IW'(acnt_reg - CW'(1));
                a_next  = IW'(acnt_reg - CW'(1));
                if (acnt_reg != '0)
                begin
                    acnt_next = acnt_reg - CW'(1);
                    if (!(!expired_reg[rd_addr] && !touched_reg[rd_addr]))
                        rd_addr = a_reg;
                end
            end
            ST_A_WAIT:
            begin
                bcnt_next = used_reg;
            end
            ST_B_RD:
            begin
                rd_addr = IW'(bcnt_reg - CW'(1));
                b_next  = IW'(bcnt_reg - CW'(1));
            end
            ST_B_CMP:
            begin
                bcnt_next = bcnt_reg - CW'(1);
                rd_addr   = b_reg;
            end
            ST_FLIP_A:
            begin
                wr_color      = 1'b1;
                wr_addr       = a_reg;
                wr_color_data = a_color_reg ^ COLOR_FLIP;
                rd_addr       = b_reg;
                touched_next[a_reg] = 1'b1;
                touched_next[b_reg] = 1'b1;
            end
            ST_FLIP_B:
            begin
                // read of partner color issued in ST_FLIP_A, rd_coll still holds b
                wr_color      = 1'b1;
                wr_addr       = b_reg;
                wr_color_data = rd_color ^ COLOR_FLIP;
                pair_next = '0;
                pair_next.kind            = KIND_PAIR;
                pair_next.first_slot      = 5'(a_reg);
                pair_next.second_slot     = 5'(b_reg);
                pair_next.first_instance  = a_data_reg.inst;
                pair_next.second_instance = rd_coll.inst;
                pair_next.first_color     = a_color_reg ^ COLOR_FLIP;
                // partner may be the same color word just flipped only if a == b (never)
                pair_next.second_color    = rd_color ^ COLOR_FLIP;
                pair_next.first_notify    = a_data_reg.notify;
                pair_next.second_notify   = rd_coll.notify;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (nres_reg < 6'(MAX_RESULTS - 1))
                    begin
                        res_valid_next = 1'b1;
                        res_next = pair_reg;
                        nres_next = nres_reg + 6'd1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/rect_collision_arena.sv =====
// ----------------------------------------------------------------------------
// rect_collision_arena
// pool of rectangle colliders with pairwise overlap detection
// ----------------------------------------------------------------------------
//  channel  | signals                         | word
//  ---------+---------------------------------+-------------------
//  input    | in_valid, in_ready, in_data     | rca_pkg::in_word_t
//  output   | out_valid, out_ready, out_data  | rca_pkg::out_word_t
//
// clear and push register their result through the command state and the output register; the next
// word is taken the cycle after the result leaves. a process walks the slot memory
// with one read port: for each live slot, from the top down, it reads the used slots as
// partners until one overlaps, then flips both colors and emits a pair word.
// reset clears the state, the output valid, the used count and the expired / touched flags, nothing else.
// the engine stalls on a full output register and takes no new word while busy.
// ----------------------------------------------------------------------------
module rect_collision_arena #(
    parameter int SLOTS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rca_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rca_pkg::out_word_t  out_data
);
    import rca_pkg::*;

    logic busy;

    assign in_ready = !busy;

    rca_engine #(.SLOTS(SLOTS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .cmd       (in_data),
        .busy      (busy),
        .res_valid (out_valid),
        .res       (out_data),
        .res_take  (out_ready)
    );

endmodule

// ===== verif/rect_collision_arena_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_collision_arena_test
// drives clear, push, process and unused-opcode words into the collider pool, predicts every
// result word from a local copy of the pool and compares field by field
// ----------------------------------------------------------------------------
module rect_collision_arena_test;
    import rca_pkg::*;

    localparam int NSLOT = 32;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_word_t  out_data;

    rect_collision_arena dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // local copy of the pool
    int          pool_used;
    coll_t       pool_coll [NSLOT];
    logic [31:0] pool_color [NSLOT];
    bit          pool_expired [NSLOT];
    bit          pool_touched [NSLOT];

    out_word_t   pending_words [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    longint      cycle_count;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit rects_touch(coll_t a, coll_t b);
        int ax, ay, bx, by;
        begin
            ax = a.x;
            ay = a.y;
            bx = b.x;
            by = b.y;
            return ax < bx + int'(b.w) && bx < ax + int'(a.w)
                && ay < by + int'(b.h) && by < ay + int'(a.h);
        end
    endfunction

    function automatic out_word_t blank_word(kind_t k);
        out_word_t w;
        begin
            w = '0;
            w.kind = k;
            w.last = 1'b1;
            return w;
        end
    endfunction

    // works out the result words of one input word and updates the pool copy
    task automatic predict_arena(input in_word_t w);
        out_word_t r;
        int slot;
        int partner;
        int n;
        begin
            case (w.opcode)
                OP_CLEAR:
                begin
                    for (int i = 0; i < pool_used; i++) pool_expired[i] = 1;
                    pending_words.push_back(blank_word(KIND_CLEARED));
                end
                OP_PUSH:
                begin
                    slot = -1;
                    for (int i = pool_used - 1; i >= 0; i--)
                        if (slot < 0 && pool_expired[i]) slot = i;
                    if (slot < 0 && pool_used >= NSLOT)
                        pending_words.push_back(blank_word(KIND_FULL));
                    else
                    begin
                        if (slot < 0)
                        begin
                            slot = pool_used;
                            pool_used++;
                        end
                        pool_coll[slot].x = w.rect_x;
                        pool_coll[slot].y = w.rect_y;
                        pool_coll[slot].w = w.rect_w;
                        pool_coll[slot].h = w.rect_h;
                        pool_coll[slot].group = w.color_in;
                        pool_coll[slot].inst = w.instance_id;
                        pool_coll[slot].notify = w.notify_enable;
                        pool_color[slot] = w.color_in;
                        pool_expired[slot] = 0;
                        pool_touched[slot] = 0;
                        r = blank_word(KIND_PUSHED);
                        r.second_slot = 5'(slot);
                        pending_words.push_back(r);
                    end
                end
                OP_PROCESS:
                begin
                    n = 0;
                    for (int a = pool_used - 1; a >= 0; a--)
                    begin
                        if (pool_expired[a] || pool_touched[a]) continue;
                        partner = -1;
                        for (int c = pool_used - 1; c >= 0; c--)
                        begin
                            if (partner >= 0 || pool_expired[c] || c == a) continue;
                            if (pool_coll[c].group == pool_coll[a].group) continue;
                            if (rects_touch(pool_coll[a], pool_coll[c])) partner = c;
                        end
                        if (partner < 0) continue;
                        pool_color[a] ^= COLOR_FLIP;
                        pool_color[partner] ^= COLOR_FLIP;
                        pool_touched[a] = 1;
                        pool_touched[partner] = 1;
                        if (n < MAX_RESULTS - 1)
                        begin
                            r = '0;
                            r.kind = KIND_PAIR;
                            r.first_slot = 5'(a);
                            r.second_slot = 5'(partner);
                            r.first_instance = pool_coll[a].inst;
                            r.second_instance = pool_coll[partner].inst;
                            r.first_color = pool_color[a];
                            r.second_color = pool_color[partner];
                            r.first_notify = pool_coll[a].notify;
                            r.second_notify = pool_coll[partner].notify;
                            pending_words.push_back(r);
                            n++;
                        end
                    end
                    pending_words.push_back(blank_word(KIND_DONE));
                end
                default: ;
            endcase
        end
    endtask

    // valid drops only when the sender idles or the stream pauses
    task automatic send_word(input in_word_t w);
        begin
            if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < send_idle_pct)
                    @(posedge clk);
            end
            predict_arena(w);
            in_valid <= 1'b1;
            in_data  <= w;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
        end
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word kind %0d", out_data.kind);
                fail_count++;
            end
            else
            begin
                e = pending_words.pop_front();
                if (out_data.kind !== e.kind)
                    $error("kind exp %0d got %0d", e.kind, out_data.kind);
                if (out_data.first_slot !== e.first_slot)
                    $error("first_slot exp %0d got %0d", e.first_slot, out_data.first_slot);
                if (out_data.second_slot !== e.second_slot)
                    $error("second_slot exp %0d got %0d", e.second_slot,
                           out_data.second_slot);
                if (out_data.first_instance !== e.first_instance)
                    $error("first_instance exp %h got %h", e.first_instance,
                           out_data.first_instance);
                if (out_data.second_instance !== e.second_instance)
                    $error("second_instance exp %h got %h", e.second_instance,
                           out_data.second_instance);
                if (out_data.first_color !== e.first_color)
                    $error("first_color exp %h got %h", e.first_color, out_data.first_color);
                if (out_data.second_color !== e.second_color)
                    $error("second_color exp %h got %h", e.second_color,
                           out_data.second_color);
                if (out_data.first_notify !== e.first_notify)
                    $error("first_notify exp %b got %b", e.first_notify,
                           out_data.first_notify);
                if (out_data.second_notify !== e.second_notify)
                    $error("second_notify exp %b got %b", e.second_notify,
                           out_data.second_notify);
                if (out_data.last !== e.last)
                    $error("last exp %b got %b", e.last, out_data.last);
                if (out_data !== e) fail_count++;
            end
        end
    end

    function automatic in_word_t op_word(opcode_t op);
        in_word_t w;
        begin
            w = '0;
            w.opcode = op;
            return w;
        end
    endfunction

    function automatic in_word_t push_word(int x, int y, int wd, int ht,
                                           logic [31:0] color);
        in_word_t w;
        begin
            w = '0;
            w.opcode = OP_PUSH;
            w.rect_x = 16'(x);
            w.rect_y = 16'(y);
            w.rect_w = 15'(wd);
            w.rect_h = 15'(ht);
            w.color_in = color;
            w.instance_id = 16'($urandom);
            w.notify_enable = 1'($urandom);
            return w;
        end
    endfunction

    function automatic in_word_t random_push();
        in_word_t w;
        begin
            // mostly a small field so that overlaps are common
            if ($urandom_range(9) < 8)
                w = push_word($urandom_range(200) - 100, $urandom_range(200) - 100,
                              $urandom_range(80), $urandom_range(80),
                              32'($urandom_range(3)) ^ {32{1'($urandom_range(1))}});
            else
            begin
                w = push_word(0, 0, 0, 0, $urandom);
                w.rect_x = 16'($urandom);
                w.rect_y = 16'($urandom);
                w.rect_w = 15'($urandom);
                w.rect_h = 15'($urandom);
            end
            return w;
        end
    endfunction

    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            while (pending_words.size() != 0) @(posedge clk);
            repeat (10) @(posedge clk);
        end
    endtask

    task automatic test_directed();
        begin
            send_word(op_word(OP_PROCESS));
            send_word(op_word(OP_CLEAR));
            send_word(push_word(-32768, -32768, 32767, 32767, 32'h0));
            send_word(push_word(32767, 32767, 32767, 32767, 32'hffffffff));
            send_word(push_word(-32768, 32767, 1, 1, 32'h1));
            send_word(push_word(0, 0, 0, 10, 32'h2));
            send_word(push_word(0, 0, 10, 0, 32'h3));
            send_word(push_word(10, 0, 5, 5, 32'h4));
            send_word(push_word(5, 0, 5, 5, 32'h5));
            send_word(push_word(0, 0, 6, 6, 32'h5));
            send_word(op_word(OP_PROCESS));
            send_word(op_word(OP_PROCESS));
            send_word(op_word(opcode_t'(2'd3)));
            send_word(op_word(OP_CLEAR));
            send_word(push_word(0, 0, 20, 20, 32'haaaa5555));
            send_word(op_word(OP_PROCESS));
            // fill the pool to the top and push past it
            for (int i = 0; i < NSLOT; i++) send_word(random_push());
            send_word(random_push());
            send_word(op_word(OP_PROCESS));
            wait_drained();
        end
    endtask

    task automatic test_random(input int count);
        int r;
        begin
            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(99);
                if (r < 70) send_word(random_push());
                else if (r < 82) send_word(op_word(OP_PROCESS));
                else if (r < 95) send_word(op_word(OP_CLEAR));
                else send_word(op_word(opcode_t'(2'd3)));
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pool_used = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            pool_expired[i] = 0;
            pool_touched[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(90);
        send_idle_pct = 51;
        test_random(80);
        send_idle_pct = 0;
        recv_stall_pct = 51;
        test_random(80);
        send_idle_pct = 8;
        recv_stall_pct = 8;
        test_random(80);
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
